// ----- design/apkc_pkg.sv -----
`timescale 1ns / 1ps

package apkc_pkg;

  localparam int ADC_W      = 8;
  localparam int VOL_W      = 7;
  localparam int CMD_W      = 8;
  localparam int FLASH_W    = 2;
  localparam int CFG_IDX_W  = 1;

  localparam logic [VOL_W-1:0] VOLUME_MAX = 7'd72;

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LEVEL  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_LEVEL = 1'd1;

  localparam logic [ADC_W-1:0] IDLE_LEVEL_RESET  = 8'd250;
  localparam logic [ADC_W-1:0] POWER_LEVEL_RESET = 8'd5;

  localparam logic [ADC_W-1:0] INPUT_LO  = 8'd20;
  localparam logic [ADC_W-1:0] INPUT_HI  = 8'd30;
  localparam logic [ADC_W-1:0] EFFECT_LO = 8'd50;
  localparam logic [ADC_W-1:0] EFFECT_HI = 8'd60;
  localparam logic [ADC_W-1:0] DOWN_LO   = 8'd104;
  localparam logic [ADC_W-1:0] DOWN_HI   = 8'd114;
  localparam logic [ADC_W-1:0] UP_LO     = 8'd135;
  localparam logic [ADC_W-1:0] UP_HI     = 8'd145;

  localparam logic [CMD_W-1:0] TENS_CMD  = 8'hD0;
  localparam logic [CMD_W-1:0] UNITS_CMD = 8'hE0;

  localparam logic [FLASH_W-1:0] FLASH_NONE = 2'd0;
  localparam logic [FLASH_W-1:0] FLASH_DOWN = 2'd1;
  localparam logic [FLASH_W-1:0] FLASH_UP   = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    KEY_NONE,
    KEY_INPUT,
    KEY_EFFECT,
    KEY_DOWN,
    KEY_UP
  } key_t;

  typedef struct packed {
    logic power_hit;
    key_t key;
  } key_item_t;

  typedef struct packed {
    logic      valid;
    key_item_t item;
  } queue_head_t;

endpackage

// ----- design/apkc_front.sv -----
`timescale 1ns / 1ps

module apkc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [apkc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [apkc_pkg::ADC_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [apkc_pkg::ADC_W-1:0]     adc_level,
  input  logic                           q_ready,
  output logic                           push,
  output apkc_pkg::key_item_t            push_item
);
  import apkc_pkg::*;

  logic [ADC_W-1:0] idle_level;
  logic [ADC_W-1:0] power_level;
  logic             below_idle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_level  <= IDLE_LEVEL_RESET;
      power_level <= POWER_LEVEL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDLE_LEVEL:  idle_level  <= cfg_data;
        CFG_POWER_LEVEL: power_level <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  // classify one sample
  always_comb begin
    below_idle          = adc_level < idle_level;
    push_item.power_hit = below_idle && (adc_level < power_level);
    push_item.key       = KEY_NONE;
    if (below_idle) begin
      if (adc_level > INPUT_LO && adc_level < INPUT_HI) begin
        push_item.key = KEY_INPUT;
      end else if (adc_level > EFFECT_LO && adc_level < EFFECT_HI) begin
        push_item.key = KEY_EFFECT;
      end else if (adc_level > DOWN_LO && adc_level < DOWN_HI) begin
        push_item.key = KEY_DOWN;
      end else if (adc_level > UP_LO && adc_level < UP_HI) begin
        push_item.key = KEY_UP;
      end
    end
  end

endmodule

// ----- design/apkc_queue.sv -----
`timescale 1ns / 1ps

module apkc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  apkc_pkg::key_item_t   push_item,
  output logic                  q_ready,
  input  logic                  pop,
  output apkc_pkg::queue_head_t head
);
  import apkc_pkg::*;

  key_item_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_ready    = count != QCNT_W'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/apkc_back.sv -----
`timescale 1ns / 1ps

module apkc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  apkc_pkg::queue_head_t        head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         power_on,
  output logic                         aux_selected,
  output logic                         normal_effect,
  output logic [apkc_pkg::VOL_W-1:0]   volume,
  output logic                         send_volume,
  output logic [apkc_pkg::CMD_W-1:0]   tens_byte,
  output logic [apkc_pkg::CMD_W-1:0]   units_byte,
  output logic                         send_input,
  output logic                         input_six_channel,
  output logic [apkc_pkg::FLASH_W-1:0] volume_key_flash
);
  import apkc_pkg::*;

  localparam int PROD_W = 2 * VOL_W + 1;
  localparam logic [PROD_W-1:0] TENS_RECIP = PROD_W'(205);
  localparam int TENS_SHIFT = 11;

  logic               powered;
  logic               source_aux;
  logic               effect_normal;
  logic [VOL_W-1:0]   volume_step;

  logic               powered_next;
  logic               source_aux_next;
  logic               effect_normal_next;
  logic [VOL_W-1:0]   volume_step_next;
  logic               send_vol;
  logic               send_in;
  logic [FLASH_W-1:0] flash;
  logic [VOL_W-1:0]   att;
  logic [PROD_W-1:0]  prod;
  logic [2:0]         tens;
  logic [VOL_W-1:0]   units;

  assign pop = head.valid && (!out_valid || out_ready);

  always_comb begin
    powered_next       = powered ^ head.item.power_hit;
    send_vol           = head.item.power_hit && !powered;
    send_in            = head.item.power_hit && !powered;
    source_aux_next    = source_aux;
    effect_normal_next = effect_normal;
    volume_step_next   = volume_step;
    flash              = FLASH_NONE;
    if (powered_next) begin
      case (head.item.key)
        KEY_INPUT: begin
          source_aux_next = !source_aux;
          send_in         = 1'b1;
        end
        KEY_EFFECT: begin
          effect_normal_next = !effect_normal;
        end
        KEY_DOWN: begin
          if (volume_step != '0) begin
            volume_step_next = volume_step - 1'b1;
          end
          send_vol = 1'b1;
          flash    = FLASH_DOWN;
        end
        KEY_UP: begin
          if (volume_step < VOLUME_MAX) begin
            volume_step_next = volume_step + 1'b1;
          end
          send_vol = 1'b1;
          flash    = FLASH_UP;
        end
        default: ;
      endcase
    end
    // divide attenuation by ten through a reciprocal multiply
    att   = VOLUME_MAX - volume_step_next;
    prod  = PROD_W'(att) * TENS_RECIP;
    tens  = prod[TENS_SHIFT +: 3];
    units = att - VOL_W'(tens) * VOL_W'(10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      powered       <= 1'b0;
      source_aux    <= 1'b1;
      effect_normal <= 1'b1;
      volume_step   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        powered       <= powered_next;
        source_aux    <= source_aux_next;
        effect_normal <= effect_normal_next;
        volume_step   <= volume_step_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      power_on          <= powered_next;
      aux_selected      <= source_aux_next;
      normal_effect     <= effect_normal_next;
      volume            <= volume_step_next;
      send_volume       <= send_vol;
      tens_byte         <= TENS_CMD | CMD_W'(tens);
      units_byte        <= UNITS_CMD | CMD_W'(units[3:0]);
      send_input        <= send_in;
      input_six_channel <= !source_aux_next;
      volume_key_flash  <= flash;
    end
  end

endmodule

// ----- design/amplifier_panel_key_controller.sv -----
// Path: an accepted sample is written into a queue entry, then the state unit registers its result on the outputs.
// Throughput: one sample per cycle while the queue has room; the two-entry queue between classifier
// and state unit lets either side stall while the output register holds.
// Reset: synchronous, active high; power off, aux source, normal effect,
// volume 0, idle level 250, power level 5, queue and output emptied.
`timescale 1ns / 1ps

module amplifier_panel_key_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [apkc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [apkc_pkg::ADC_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [apkc_pkg::ADC_W-1:0]     adc_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           power_on,
  output logic                           aux_selected,
  output logic                           normal_effect,
  output logic [apkc_pkg::VOL_W-1:0]     volume,
  output logic                           send_volume,
  output logic [apkc_pkg::CMD_W-1:0]     tens_byte,
  output logic [apkc_pkg::CMD_W-1:0]     units_byte,
  output logic                           send_input,
  output logic                           input_six_channel,
  output logic [apkc_pkg::FLASH_W-1:0]   volume_key_flash
);
  import apkc_pkg::*;

  logic        push;
  key_item_t   push_item;
  logic        q_ready;
  logic        pop;
  queue_head_t head;

  apkc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .adc_level (adc_level),
    .q_ready   (q_ready),
    .push      (push),
    .push_item (push_item)
  );

  apkc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .pop       (pop),
    .head      (head)
  );

  apkc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .power_on          (power_on),
    .aux_selected      (aux_selected),
    .normal_effect     (normal_effect),
    .volume            (volume),
    .send_volume       (send_volume),
    .tens_byte         (tens_byte),
    .units_byte        (units_byte),
    .send_input        (send_input),
    .input_six_channel (input_six_channel),
    .volume_key_flash  (volume_key_flash)
  );

  a_volume_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> volume <= VOLUME_MAX)
    else $error("volume beyond limit");

  a_flash_sends: assert property (@(posedge clk) disable iff (rst)
    out_valid && volume_key_flash != FLASH_NONE |-> send_volume && power_on)
    else $error("volume flash without attenuator write");

  a_off_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !power_on |-> !send_volume && !send_input)
    else $error("write requested while powered off");

  a_source_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> input_six_channel != aux_selected)
    else $error("selector code disagrees with source");

  a_cmd_prefix: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tens_byte[7:3] == 5'b11010 && units_byte[7:4] == 4'hE)
    else $error("attenuator command prefix wrong");

endmodule
